// ----- hdl/mdes_pkg.sv -----
// MIPS decode/execute package: opcode and funct codes, store sizes,
// and the item and result types shared by the execute logic and the top level.
// No dependencies.
package mdes_pkg;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2B;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_JALR = 6'h09;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  localparam logic [1:0] SIZE_WORD = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_BYTE = 2'd2;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_LINK = 5'd31;

  typedef struct packed {
    logic [31:0] rt_value;
    logic [31:0] rs_value;
    logic [31:0] instr_pc;
    logic [31:0] instr;
  } item_t;

  typedef struct packed {
    logic        illegal;
    logic [31:0] next_pc;
    logic        redirect;
    logic [1:0]  store_size;
    logic [31:0] store_data;
    logic [31:0] mem_addr;
    logic        mem_write;
    logic        mem_read;
    logic        reg_write;
    logic [4:0]  dest_reg;
    logic [31:0] alu_result;
  } result_t;

endpackage

// ----- hdl/mdes_exec.sv -----
// Decode and execute logic for one MIPS instruction: ALU, address, store
// data, branch and jump resolution. Combinational. Depends on mdes_pkg.
module mdes_exec (
  input  mdes_pkg::item_t   item,
  output mdes_pkg::result_t res
);
  import mdes_pkg::*;

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  shamt;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] seq_pc;
  logic [31:0] link_pc;
  logic [31:0] br_target;
  logic [31:0] j_target;
  logic [31:0] ea;

  assign op        = item.instr[31:26];
  assign fn        = item.instr[5:0];
  assign rt        = item.instr[20:16];
  assign rd        = item.instr[15:11];
  assign shamt     = item.instr[10:6];
  assign imm       = {16'h0000, item.instr[15:0]};
  assign simm      = {{16{item.instr[15]}}, item.instr[15:0]};
  assign a         = item.rs_value;
  assign b         = item.rt_value;
  assign seq_pc    = item.instr_pc + 32'd4;
  assign link_pc   = item.instr_pc + 32'd8;
  assign br_target = seq_pc + {simm[29:0], 2'b00};
  assign j_target  = {seq_pc[31:28], item.instr[25:0], 2'b00};
  assign ea        = a + simm;

  always_comb begin
    res = '0;
    res.next_pc = seq_pc;
    if (op == OP_RTYPE) begin
      res.reg_write = 1'b1;
      res.dest_reg  = rd;
      case (fn)
        FN_ADD, FN_ADDU: res.alu_result = a + b;
        FN_SUB, FN_SUBU: res.alu_result = a - b;
        FN_AND:          res.alu_result = a & b;
        FN_OR:           res.alu_result = a | b;
        FN_NOR:          res.alu_result = ~(a | b);
        FN_SLT:          res.alu_result = {31'd0, $signed(a) < $signed(b)};
        FN_SLTU:         res.alu_result = {31'd0, a < b};
        FN_SLL:          res.alu_result = b << shamt;
        FN_SRL:          res.alu_result = b >> shamt;
        FN_JR: begin
          res.reg_write = 1'b0;
          res.dest_reg  = REG_ZERO;
          res.next_pc   = a;
        end
        FN_JALR: begin
          res.dest_reg   = REG_LINK;
          res.alu_result = link_pc;
          res.next_pc    = a;
        end
        default: begin
          res.illegal   = 1'b1;
          res.reg_write = 1'b0;
          res.dest_reg  = REG_ZERO;
        end
      endcase
    end else begin
      case (op)
        OP_J: res.next_pc = j_target;
        OP_JAL: begin
          res.next_pc    = j_target;
          res.reg_write  = 1'b1;
          res.dest_reg   = REG_LINK;
          res.alu_result = link_pc;
        end
        OP_BEQ: if (a == b) res.next_pc = br_target;
        OP_BNE: if (a != b) res.next_pc = br_target;
        OP_ADDI, OP_ADDIU: begin
          res.reg_write  = 1'b1;
          res.dest_reg   = rt;
          res.alu_result = ea;
        end
        OP_SLTI: begin
          res.reg_write  = 1'b1;
          res.dest_reg   = rt;
          res.alu_result = {31'd0, $signed(a) < $signed(simm)};
        end
        OP_SLTIU: begin
          res.reg_write  = 1'b1;
          res.dest_reg   = rt;
          res.alu_result = {31'd0, a < simm};
        end
        OP_ANDI: begin
          res.reg_write  = 1'b1;
          res.dest_reg   = rt;
          res.alu_result = a & imm;
        end
        OP_ORI: begin
          res.reg_write  = 1'b1;
          res.dest_reg   = rt;
          res.alu_result = a | imm;
        end
        OP_LUI: begin
          res.reg_write  = 1'b1;
          res.dest_reg   = rt;
          res.alu_result = {item.instr[15:0], 16'h0000};
        end
        OP_LW: begin
          res.reg_write  = 1'b1;
          res.mem_read   = 1'b1;
          res.dest_reg   = rt;
          res.alu_result = ea;
        end
        OP_SW: begin
          res.mem_write  = 1'b1;
          res.mem_addr   = ea;
          res.store_data = b;
          res.store_size = SIZE_WORD;
        end
        OP_SH: begin
          res.mem_write  = 1'b1;
          res.mem_addr   = ea;
          res.store_data = {16'h0000, b[15:0]};
          res.store_size = SIZE_HALF;
        end
        OP_SB: begin
          res.mem_write  = 1'b1;
          res.mem_addr   = ea;
          res.store_data = {24'h000000, b[7:0]};
          res.store_size = SIZE_BYTE;
        end
        default: res.illegal = 1'b1;
      endcase
    end
    res.redirect = (res.next_pc != seq_pc);
  end

endmodule

// ----- hdl/mips_decode_execute_stage.sv -----
// MIPS decode/execute stage top level: input register, execute logic and
// result register with stream handshakes. Depends on mdes_pkg and mdes_exec.
//
// Takes one instruction request per clock while the output does not stall,
// with its pc and forwarded rs/rt values, and returns one result per request,
// in order. The request lands in the input register at the accepting edge,
// and the decode/ALU logic then loads the result register, which drives
// out_tvalid. Sustained rate is one instruction per cycle; a stall on the
// output holds both registers, and in_tready stays high while the input
// register is empty or the result register can take its contents. There is
// no configuration and no state beyond the two pipeline registers.
module mips_decode_execute_stage (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // instr[31:0], instr_pc[63:32], rs_value[95:64], rt_value[127:96]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // alu_result[31:0], dest_reg[36:32], reg_write[37], mem_read[38],
  // mem_write[39], mem_addr[71:40], store_data[103:72], store_size[105:104],
  // redirect[106], next_pc[138:107], illegal[139], zero[143:140]
  output logic [143:0] out_tdata
);
  import mdes_pkg::*;

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t out_res_nxt;
  logic    out_adv;

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;

  mdes_exec u_exec (
    .item (s1_item_r),
    .res  (out_res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (out_adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.instr    <= in_tdata[31:0];
      s1_item_r.instr_pc <= in_tdata[63:32];
      s1_item_r.rs_value <= in_tdata[95:64];
      s1_item_r.rt_value <= in_tdata[127:96];
    end
    if (out_adv && s1_valid_r) out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0,
                       out_res_r.illegal,
                       out_res_r.next_pc,
                       out_res_r.redirect,
                       out_res_r.store_size,
                       out_res_r.store_data,
                       out_res_r.mem_addr,
                       out_res_r.mem_write,
                       out_res_r.mem_read,
                       out_res_r.reg_write,
                       out_res_r.dest_reg,
                       out_res_r.alu_result};

`ifndef SYNTHESIS
  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.illegal |->
      !out_res_r.reg_write && !out_res_r.mem_read && !out_res_r.mem_write &&
      !out_res_r.redirect)
    else $error("illegal instruction drives a control");

  a_load_writes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.mem_read |->
      out_res_r.reg_write && !out_res_r.mem_write)
    else $error("load without register write or with store");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register lost while stalled");

  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_adv && s1_valid_r |=> out_valid_r)
    else $error("result register did not take an item");
`endif

endmodule
